// ===== src/rvm_pkg.sv =====
// Package for the register VM execute unit: opcodes, status codes, widths
// and the command/status structs that join the controller and the datapath.
// Depends on nothing.
`timescale 1ns / 1ps

package rvm_pkg;

    localparam int INSTR_W     = 16;
    localparam int OPC_W       = 4;
    localparam int REG_FIELD_W = 4;
    localparam int IMM_W       = 8;
    localparam int DATA_W      = 64;
    localparam int HALF_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int CNT_W       = 6;

    // Opcodes
    localparam logic [OPC_W-1:0] OP_LDIMM  = 4'd0;
    localparam logic [OPC_W-1:0] OP_ADD    = 4'd1;
    localparam logic [OPC_W-1:0] OP_SUB    = 4'd2;
    localparam logic [OPC_W-1:0] OP_DIV    = 4'd3;
    localparam logic [OPC_W-1:0] OP_MUL    = 4'd4;
    localparam logic [OPC_W-1:0] OP_MOVRES = 4'd5;
    localparam logic [OPC_W-1:0] OP_DONE   = 4'd6;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_SUCCESS = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DIVZERO = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd3;

    // Step counter end points: the multiplier takes four steps over three
    // partial products, the divider one quotient bit per step.
    localparam logic [CNT_W-1:0] MUL_LAST = 6'd3;
    localparam logic [CNT_W-1:0] DIV_LAST = 6'd63;

    typedef struct packed {
        logic accept;
        logic exec;
        logic mul_step;
        logic div_step;
        logic commit;
    } rvm_cmd_t;

    typedef struct packed {
        logic [OPC_W-1:0] opcode;
        logic             b_zero;
        logic             mul_last;
        logic             div_last;
        logic             out_free;
    } rvm_sts_t;

endpackage

// ===== src/register_vm_execute_unit_core.sv =====
// Top level of the register VM execute unit: joins controller and datapath.
// Depends on rvm_pkg, rvm_ctrl and rvm_dp.
//
//  channel   | handshake                   | payload
//  ----------+-----------------------------+-------------------------------
//  request   | instr_valid / instr_stall   | instruction[15:0]
//  result    | result_valid / result_stall | status[1:0], result_value[63:0]
//
// Sequencing: one request at a time. Load, add, sub, move-result, done and
// error cases go from execute straight to commit; multiply iterates on
// the single 32x32 multiplier doing three partial products; divide iterates
// on the divider retiring one quotient bit a cycle.
// Reset: the register file reads as zero through per-entry valid bits that
// reset clears; the result register clears to zero.
// Stalls: a stalled result is held in the output register; the next request
// is accepted and executed, and waits before commit until the result is taken.
`timescale 1ns / 1ps

module register_vm_execute_unit_core
#(
    parameter int REG_COUNT = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         instr_valid,
    output logic                         instr_stall,
    input  logic [rvm_pkg::INSTR_W-1:0]  instruction,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [rvm_pkg::STATUS_W-1:0] status,
    output logic [rvm_pkg::DATA_W-1:0]   result_value
);

    // Command and status between the sequencer and the datapath
    rvm_pkg::rvm_cmd_t cmd;
    rvm_pkg::rvm_sts_t sts;

    // Sequencer: accept, execute, iterate, commit
    rvm_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .instr_valid (instr_valid),
        .instr_stall (instr_stall),
        .sts         (sts),
        .cmd         (cmd)
    );

    // Datapath: register file, arithmetic units, result and output registers
    rvm_dp #(
        .REG_COUNT (REG_COUNT)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .instruction  (instruction),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .result_value (result_value)
    );

endmodule

// ===== src/rvm_ctrl.sv =====
// Controller of the register VM execute unit: sequences accept, operand
// read, multi-cycle multiply/divide and commit. Depends on rvm_pkg.
`timescale 1ns / 1ps

module rvm_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              instr_valid,
    output logic              instr_stall,
    input  rvm_pkg::rvm_sts_t sts,
    output rvm_pkg::rvm_cmd_t cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_MULT   = 3'd2;
    localparam logic [2:0] S_DIVD   = 3'd3;
    localparam logic [2:0] S_COMMIT = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign instr_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (instr_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                priority if (sts.opcode == rvm_pkg::OP_MUL)
                    state_next = S_MULT;
                else if (sts.opcode == rvm_pkg::OP_DIV && !sts.b_zero)
                    state_next = S_DIVD;
                else
                    state_next = S_COMMIT;
            end
            S_MULT:
            begin
                cmd.mul_step = 1'b1;
                if (sts.mul_last)
                    state_next = S_COMMIT;
            end
            S_DIVD:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                    state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                // hold until the output register can take the result
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVD) |-> !sts.b_zero)
        else $error("divider running on a zero divisor");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> (state_reg == S_EXEC) && instr_stall)
        else $error("accepted request not taken into execute");

endmodule

// ===== src/rvm_dp.sv =====
// Datapath of the register VM execute unit: register file with valid bits,
// result register, shared 32x32 multiplier, bit-serial divider and the
// output register. Depends on rvm_pkg.
`timescale 1ns / 1ps

module rvm_dp
#(
    parameter int REG_COUNT = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [rvm_pkg::INSTR_W-1:0]         instruction,
    input  rvm_pkg::rvm_cmd_t                   cmd,
    output rvm_pkg::rvm_sts_t                   sts,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [rvm_pkg::STATUS_W-1:0]        status,
    output logic [rvm_pkg::DATA_W-1:0]          result_value
);

    localparam int IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int LIM_W = rvm_pkg::REG_FIELD_W + 1;
    localparam logic [LIM_W-1:0] REG_LIMIT = LIM_W'(REG_COUNT);
    localparam int DW = rvm_pkg::DATA_W;
    localparam int HW = rvm_pkg::HALF_W;

    // Instruction register and decoded fields
    logic [rvm_pkg::INSTR_W-1:0]     ir_reg;
    logic [rvm_pkg::OPC_W-1:0]       opc;
    logic [rvm_pkg::REG_FIELD_W-1:0] ra;
    logic [rvm_pkg::REG_FIELD_W-1:0] rd;
    logic [rvm_pkg::IMM_W-1:0]       imm;
    logic [rvm_pkg::REG_FIELD_W-1:0] in_ra;
    logic [rvm_pkg::REG_FIELD_W-1:0] in_rb;

    assign opc   = ir_reg[15:12];
    assign ra    = ir_reg[11:8];
    assign rd    = ir_reg[3:0];
    assign imm   = ir_reg[7:0];
    assign in_ra = instruction[11:8];
    assign in_rb = instruction[7:4];

    // Register file
    logic [DW-1:0]        mem [REG_COUNT];
    logic [REG_COUNT-1:0] vld_reg;
    logic [DW-1:0]        a_rd_reg;
    logic [DW-1:0]        b_rd_reg;
    logic                 a_ok_reg;
    logic                 b_ok_reg;
    logic [DW-1:0]        a_op;
    logic [DW-1:0]        b_op;
    logic                 ra_in_rng;
    logic                 rb_in_rng;

    // Write-back
    logic                            wr_en;
    logic [rvm_pkg::REG_FIELD_W-1:0] wr_idx;
    logic [DW-1:0]                   wr_data;
    logic                            wr_op;
    logic [rvm_pkg::STATUS_W-1:0]    st_code;

    // Multiplier and divider
    logic [rvm_pkg::CNT_W-1:0] cnt_reg;
    logic [DW-1:0]             prod_reg;
    logic [DW-1:0]             acc_reg;
    logic [HW-1:0]             mul_x;
    logic [HW-1:0]             mul_y;
    logic [DW-1:0]             quo_reg;
    logic [DW-1:0]             rem_reg;
    logic [DW:0]               div_shift;
    logic [DW:0]               div_diff;
    logic                      div_ge;

    // Result and output registers
    logic [DW-1:0]                res_reg;
    logic [DW-1:0]                res_next;
    logic                         result_valid_reg;
    logic [rvm_pkg::STATUS_W-1:0] status_reg;
    logic [DW-1:0]                value_reg;

    assign ra_in_rng = ({1'b0, in_ra} < REG_LIMIT);
    assign rb_in_rng = ({1'b0, in_rb} < REG_LIMIT);

    assign a_op = a_ok_reg ? a_rd_reg : '0;
    assign b_op = b_ok_reg ? b_rd_reg : '0;

    // Registered two-port read at accept; write at commit
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_idx[IDX_W-1:0]] <= wr_data;
        if (cmd.accept)
        begin
            ir_reg   <= instruction;
            a_rd_reg <= mem[in_ra[IDX_W-1:0]];
            b_rd_reg <= mem[in_rb[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            a_ok_reg <= 1'b0;
            b_ok_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                vld_reg[wr_idx[IDX_W-1:0]] <= 1'b1;
            if (cmd.accept)
            begin
                a_ok_reg <= ra_in_rng && vld_reg[in_ra[IDX_W-1:0]];
                b_ok_reg <= rb_in_rng && vld_reg[in_rb[IDX_W-1:0]];
            end
        end
    end

    // Shared multiplier: low*low, low*high, high*low, one product a step
    always_comb
    begin
        unique case (cnt_reg[1:0])
            2'd0:
            begin
                mul_x = a_op[HW-1:0];
                mul_y = b_op[HW-1:0];
            end
            2'd1:
            begin
                mul_x = a_op[HW-1:0];
                mul_y = b_op[DW-1:HW];
            end
            default:
            begin
                mul_x = a_op[DW-1:HW];
                mul_y = b_op[HW-1:0];
            end
        endcase
    end

    // Restoring divider step
    assign div_shift = {rem_reg, quo_reg[DW-1]};
    assign div_ge    = (div_shift >= {1'b0, b_op});
    assign div_diff  = div_shift - {1'b0, b_op};

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            cnt_reg <= '0;
            quo_reg <= a_op;
            rem_reg <= '0;
        end
        else if (cmd.mul_step)
        begin
            cnt_reg  <= cnt_reg + 1'b1;
            prod_reg <= mul_x * mul_y;
            if (cnt_reg == 6'd1)
                acc_reg <= prod_reg;
            else if (cnt_reg != 6'd0)
                acc_reg <= acc_reg + {prod_reg[HW-1:0], {HW{1'b0}}};
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (div_ge)
            begin
                rem_reg <= div_diff[DW-1:0];
                quo_reg <= {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= div_shift[DW-1:0];
                quo_reg <= {quo_reg[DW-2:0], 1'b0};
            end
        end
    end

    // Write-back selection
    always_comb
    begin
        wr_op   = 1'b1;
        wr_idx  = rd;
        wr_data = '0;
        st_code = rvm_pkg::ST_SUCCESS;
        unique case (opc)
            rvm_pkg::OP_LDIMM:
            begin
                wr_idx  = ra;
                wr_data = {{(DW - rvm_pkg::IMM_W){1'b0}}, imm};
            end
            rvm_pkg::OP_ADD:    wr_data = a_op + b_op;
            rvm_pkg::OP_SUB:    wr_data = a_op - b_op;
            rvm_pkg::OP_MUL:    wr_data = acc_reg;
            rvm_pkg::OP_DIV:
            begin
                wr_data = quo_reg;
                if (b_op == '0)
                begin
                    wr_op   = 1'b0;
                    st_code = rvm_pkg::ST_DIVZERO;
                end
            end
            rvm_pkg::OP_MOVRES: wr_op = 1'b0;
            rvm_pkg::OP_DONE:
            begin
                wr_op   = 1'b0;
                st_code = rvm_pkg::ST_DONE;
            end
            default:
            begin
                wr_op   = 1'b0;
                st_code = rvm_pkg::ST_UNKNOWN;
            end
        endcase
    end

    assign wr_en    = cmd.commit && wr_op && ({1'b0, wr_idx} < REG_LIMIT);
    assign res_next = (opc == rvm_pkg::OP_MOVRES) ? a_op : res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                res_reg          <= res_next;
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            status_reg <= st_code;
            value_reg  <= res_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign status       = status_reg;
    assign result_value = value_reg;

    assign sts.opcode   = opc;
    assign sts.b_zero   = (b_op == '0);
    assign sts.mul_last = (cnt_reg == rvm_pkg::MUL_LAST);
    assign sts.div_last = (cnt_reg == rvm_pkg::DIV_LAST);
    assign sts.out_free = !result_valid_reg || !result_stall;

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!result_valid_reg || !result_stall))
        else $error("commit overwrote a pending result");

    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> ({1'b0, wr_idx} < REG_LIMIT))
        else $error("register write beyond the file");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> result_valid && (result_value == res_reg))
        else $error("output does not show the result register after commit");

endmodule
